// File: rtl/stc_pkg.sv
// Shared types and constants of the supply trim calibrator.
package stc_pkg;

  localparam int CODE_W      = 4;
  localparam int SUPPLY_W    = 3;
  localparam int GEN_W       = 2;
  localparam int RUN_W       = 6;
  localparam int HIST_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int TX_SUPPLIES = 3;

  localparam logic [CODE_W-1:0] CODE_MAX      = 4'd15;
  localparam logic [CODE_W-1:0] CODE_MIN      = 4'd0;
  localparam logic [HIST_W-1:0] DITHER_A      = 4'ha;
  localparam logic [HIST_W-1:0] DITHER_B      = 4'h5;
  localparam logic [CODE_W-1:0] DEF_CODE_RST  = 4'd8;
  localparam logic [RUN_W-1:0]  RUN_LIMIT_RST = 6'd32;

  // operation codes of an input beat
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTINUOUS = 3'd0,
    CFG_OVERRIDE   = 3'd1,
    CFG_SERDES     = 3'd2,
    CFG_DEF_CODE   = 3'd3,
    CFG_RUN_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              continuous;
    logic              override_en;
    logic              serdes;
    logic [CODE_W-1:0] default_code;
    logic [RUN_W-1:0]  run_limit;
  } cfg_t;

  // decoded input beat held between the read stage and the execute stage
  typedef struct packed {
    logic operation;
    logic supply_ok;
    logic tx_side;
    logic comp;
    logic idle;
    logic squelch;
  } item_t;

endpackage

// File: rtl/stc_channels.sv
// Valid/ready channel interfaces for input beats and result beats.
interface stc_in_if import stc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SUPPLY_W-1:0] supply_select;
  logic [GEN_W-1:0]    speed_gen;
  logic                comparator_high;
  logic                tx_idle;
  logic                rx_squelch;

  modport source (output valid, operation, supply_select, speed_gen, comparator_high,
                  tx_idle, rx_squelch, input ready);
  modport sink (input valid, operation, supply_select, speed_gen, comparator_high,
                tx_idle, rx_squelch, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_out;
  logic              done_res;
  logic              passed;
  logic              skipped;

  modport source (output valid, code_out, done_res, passed, skipped, input ready);
  modport sink (input valid, code_out, done_res, passed, skipped, output ready);
endinterface

// File: rtl/supply_trim_calibrator.sv
// Top level of the supply trim calibrator: config, read stage, table banks and execute engine.
//
//   channel  | dir | payload                                                  | handshake
//   in_ch    | in  | operation, supply_select, speed_gen, comparator_high,    | valid/ready
//            |     | tx_idle, rx_squelch                                      |
//   out_ch   | out | code_out, done_res, passed, skipped                      | valid/ready
//   cfg_*    | in  | cfg_index, cfg_data                                      | cfg_we only
//
// One beat per cycle sustained while out_ch does not stall; a result goes from in_ch through
// the read stage register (table read at the accepting edge) and into the result register.
// Reset clears the run state and the table valid bits at once; no clearing pass.
// A stalled result holds the execute stage, and in_ch then takes at most one more beat.
module supply_trim_calibrator import stc_pkg::*; #(
  parameter int NUM_GENS     = 4,
  parameter int NUM_SUPPLIES = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  stc_in_if.sink                in_ch,
  stc_out_if.source             out_ch
);

  localparam int DEPTH = NUM_SUPPLIES * NUM_GENS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  item_t             s1_item_r, s1_item_nxt;
  logic [AW-1:0]     s1_addr_r, s1_addr_nxt;
  logic              take;
  logic              in_acc;
  logic [GEN_W-1:0]  gen_eff;
  logic              wr_onetime_en, wr_cont_en;
  logic [AW-1:0]     wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [CODE_W-1:0] rd_onetime, rd_cont;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.continuous   <= 1'b0;
      cfg_r.override_en  <= 1'b0;
      cfg_r.serdes       <= 1'b0;
      cfg_r.default_code <= DEF_CODE_RST;
      cfg_r.run_limit    <= RUN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONTINUOUS: cfg_r.continuous   <= cfg_data[0];
        CFG_OVERRIDE:   cfg_r.override_en  <= cfg_data[0];
        CFG_SERDES:     cfg_r.serdes       <= cfg_data[0];
        CFG_DEF_CODE:   cfg_r.default_code <= cfg_data[CODE_W-1:0];
        CFG_RUN_LIMIT:  cfg_r.run_limit    <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode: effective generation and table address
  always_comb begin
    if (cfg_r.serdes) begin
      gen_eff = '0;
    end else if (32'(in_ch.speed_gen) >= NUM_GENS) begin
      gen_eff = GEN_W'(NUM_GENS - 1);
    end else begin
      gen_eff = in_ch.speed_gen;
    end
    s1_item_nxt.operation = in_ch.operation;
    s1_item_nxt.supply_ok = 32'(in_ch.supply_select) < NUM_SUPPLIES;
    s1_item_nxt.tx_side   = 32'(in_ch.supply_select) < TX_SUPPLIES;
    s1_item_nxt.comp      = in_ch.comparator_high;
    s1_item_nxt.idle      = in_ch.tx_idle;
    s1_item_nxt.squelch   = in_ch.rx_squelch;
    if (s1_item_nxt.supply_ok) begin
      s1_addr_nxt = AW'(32'(in_ch.supply_select) * NUM_GENS + 32'(gen_eff));
    end else begin
      s1_addr_nxt = '0;
    end
  end

  assign in_ch.ready = !s1_valid_r || take;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // read stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= s1_item_nxt;
      s1_addr_r <= s1_addr_nxt;
    end
  end

  // one-time slot bank
  stc_trim_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_onetime (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_onetime_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (s1_addr_nxt),
    .rd_data (rd_onetime)
  );

  // continuous slot bank
  stc_trim_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_cont (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_cont_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (s1_addr_nxt),
    .rd_data (rd_cont)
  );

  stc_engine #(.AW(AW)) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .item_valid    (s1_valid_r),
    .item          (s1_item_r),
    .item_addr     (s1_addr_r),
    .rd_onetime    (rd_onetime),
    .rd_cont       (rd_cont),
    .item_take     (take),
    .wr_onetime_en (wr_onetime_en),
    .wr_cont_en    (wr_cont_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_ch        (out_ch)
  );

endmodule

// File: rtl/stc_trim_bank.sv
// One bank of the trim table: synchronous RAM with valid bits and write forwarding.
module stc_trim_bank import stc_pkg::*; #(
  parameter int DEPTH = 24,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CODE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CODE_W-1:0] rd_data
);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [CODE_W-1:0] rd_data_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entry valid bits, cleared at reset so unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read, held between reads; same-edge write is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= CODE_MIN;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/stc_engine.sv
// Execute stage: run state, code search, table write-back and result register.
module stc_engine import stc_pkg::*; #(
  parameter int AW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  item_t             item,
  input  logic [AW-1:0]     item_addr,
  input  logic [CODE_W-1:0] rd_onetime,
  input  logic [CODE_W-1:0] rd_cont,
  output logic              item_take,
  output logic              wr_onetime_en,
  output logic              wr_cont_en,
  output logic [AW-1:0]     wr_addr,
  output logic [CODE_W-1:0] wr_data,
  stc_out_if.source         out_ch
);

  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [RUN_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [AW-1:0]     act_addr_r, act_addr_nxt;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_pass_r, out_pass_nxt;
  logic              out_skip_r, out_skip_nxt;

  logic [CODE_W-1:0] stored;
  logic [HIST_W-1:0] shifted;
  logic [CODE_W-1:0] stepped;
  logic              pass;
  logic              stop;

  // the result register frees up when empty or being drained
  assign item_take = item_valid && (!out_valid_r || out_ch.ready);

  assign stored  = cfg.continuous ? rd_cont : rd_onetime;
  assign shifted = {hist_r[HIST_W-2:0], item.comp};
  assign pass    = (shifted == DITHER_A) || (shifted == DITHER_B);
  assign stop    = pass || cfg.continuous || (run_cnt_r >= cfg.run_limit);

  // saturating one-step move of the code
  always_comb begin
    if (item.comp) begin
      stepped = (code_r == CODE_MIN) ? code_r : code_r - 4'd1;
    end else begin
      stepped = (code_r == CODE_MAX) ? code_r : code_r + 4'd1;
    end
  end

  // per-beat update of the run state
  always_comb begin
    busy_nxt      = busy_r;
    code_nxt      = code_r;
    hist_nxt      = hist_r;
    run_cnt_nxt   = run_cnt_r;
    act_addr_nxt  = act_addr_r;
    out_code_nxt  = code_r;
    out_done_nxt  = 1'b0;
    out_pass_nxt  = 1'b0;
    out_skip_nxt  = 1'b0;
    wr_onetime_en = 1'b0;
    wr_cont_en    = 1'b0;
    if (item.operation == OP_START) begin
      busy_nxt = 1'b0;
      if (!item.supply_ok) begin
        out_code_nxt = CODE_MIN;
        out_done_nxt = 1'b1;
      end else if (cfg.override_en) begin
        out_code_nxt = stored;
        out_done_nxt = 1'b1;
      end else if (cfg.continuous && (item.tx_side ? item.idle : item.squelch)) begin
        out_code_nxt = CODE_MIN;
        out_skip_nxt = 1'b1;
      end else begin
        busy_nxt     = 1'b1;
        act_addr_nxt = item_addr;
        code_nxt     = cfg.continuous ? rd_cont : cfg.default_code;
        hist_nxt     = '0;
        run_cnt_nxt  = '0;
        out_code_nxt = code_nxt;
      end
    end else if (busy_r) begin
      hist_nxt     = shifted;
      code_nxt     = stepped;
      out_code_nxt = stepped;
      if (stop) begin
        busy_nxt      = 1'b0;
        out_done_nxt  = 1'b1;
        out_pass_nxt  = pass;
        wr_cont_en    = 1'b1;
        wr_onetime_en = !cfg.continuous;
      end else begin
        run_cnt_nxt = run_cnt_r + 6'd1;
      end
    end
    if (!item_take) begin
      wr_onetime_en = 1'b0;
      wr_cont_en    = 1'b0;
    end
  end

  assign wr_addr = act_addr_r;
  assign wr_data = stepped;

  // run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      code_r     <= '0;
      hist_r     <= '0;
      run_cnt_r  <= '0;
      act_addr_r <= '0;
    end else if (item_take) begin
      busy_r     <= busy_nxt;
      code_r     <= code_nxt;
      hist_r     <= hist_nxt;
      run_cnt_r  <= run_cnt_nxt;
      act_addr_r <= act_addr_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_code_r <= out_code_nxt;
      out_done_r <= out_done_nxt;
      out_pass_r <= out_pass_nxt;
      out_skip_r <= out_skip_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.code_out = out_code_r;
  assign out_ch.done_res = out_done_r;
  assign out_ch.passed   = out_pass_r;
  assign out_ch.skipped  = out_skip_r;

endmodule

// File: tb/supply_trim_calibrator_chk.sv
// Checker of the supply trim calibrator: tracks config, predicts each result beat and compares.
module supply_trim_calibrator_chk import stc_pkg::*; #(
  parameter int NUM_GENS     = 4,
  parameter int NUM_SUPPLIES = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  stc_in_if                     in_ch,
  stc_out_if                    out_ch,
  output int                    err_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIM_DEPTH = NUM_SUPPLIES * 2 * NUM_GENS;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              done;
    logic              passed;
    logic              skipped;
  } trim_res_t;

  // predictor copy of the registers and run state
  cfg_t                live_cfg;
  logic [CODE_W-1:0]   trim_mem [TRIM_DEPTH];
  logic [CODE_W-1:0]   cur_code;
  logic [HIST_W-1:0]   hist;
  logic [RUN_W-1:0]    run_cnt;
  logic                run_busy;
  logic [SUPPLY_W-1:0] act_supply;
  logic [GEN_W-1:0]    act_gen;

  trim_res_t           want_q [$];
  int                  err_tally = 0;

  assign err_count = err_tally;

  function automatic int trim_slot(logic [SUPPLY_W-1:0] sup, logic slot, int gen);
    int idx;
    idx = (int'(sup) * 2 + int'(slot)) * NUM_GENS + gen;
    if (idx >= TRIM_DEPTH) idx = 0;
    return idx;
  endfunction

  function automatic int gen_eff(logic [GEN_W-1:0] g);
    if (live_cfg.serdes) return 0;
    if (int'(g) >= NUM_GENS) return NUM_GENS - 1;
    return int'(g);
  endfunction

  task automatic trim_reset();
    live_cfg.continuous   = 1'b0;
    live_cfg.override_en  = 1'b0;
    live_cfg.serdes       = 1'b0;
    live_cfg.default_code = DEF_CODE_RST;
    live_cfg.run_limit    = RUN_LIMIT_RST;
    foreach (trim_mem[i]) trim_mem[i] = '0;
    cur_code   = '0;
    hist       = '0;
    run_cnt    = '0;
    run_busy   = 1'b0;
    act_supply = '0;
    act_gen    = '0;
  endtask

  // one input beat in, the result it causes out
  function automatic trim_res_t predict_trim(logic op, logic [SUPPLY_W-1:0] sup,
                                             logic [GEN_W-1:0] gen_in, logic comp,
                                             logic idle, logic squelch);
    trim_res_t r;
    int        g;
    logic      hit;
    logic      stop;
    r = '0;
    if (op == OP_START) begin
      run_busy = 1'b0;
      if (int'(sup) >= NUM_SUPPLIES) begin
        r.done = 1'b1;
        return r;
      end
      g = gen_eff(gen_in);
      if (live_cfg.override_en) begin
        r.code = trim_mem[trim_slot(sup, live_cfg.continuous, g)];
        r.done = 1'b1;
        return r;
      end
      // tracking refused on an idle transmitter or squelched receiver
      if (live_cfg.continuous && ((int'(sup) < TX_SUPPLIES && idle) ||
                                  (int'(sup) >= TX_SUPPLIES && squelch))) begin
        r.skipped = 1'b1;
        return r;
      end
      act_supply = sup;
      act_gen    = GEN_W'(g);
      cur_code   = live_cfg.continuous ? trim_mem[trim_slot(sup, 1'b1, g)]
                                       : live_cfg.default_code;
      hist       = '0;
      run_cnt    = '0;
      run_busy   = 1'b1;
      r.code     = cur_code;
      return r;
    end

    // sample with no run open leaves everything alone
    if (!run_busy) begin
      r.code = cur_code;
      return r;
    end

    hist = {hist[HIST_W-2:0], comp};
    if (comp) begin
      if (cur_code != CODE_MIN) cur_code = cur_code - 1'b1;
    end else begin
      if (cur_code != CODE_MAX) cur_code = cur_code + 1'b1;
    end
    hit    = (hist == DITHER_A) || (hist == DITHER_B);
    stop   = hit || live_cfg.continuous || (run_cnt >= live_cfg.run_limit);
    r.code = cur_code;
    if (!stop) begin
      run_cnt = run_cnt + 1'b1;
      return r;
    end
    trim_mem[trim_slot(act_supply, live_cfg.continuous, int'(act_gen))] = cur_code;
    if (!live_cfg.continuous) trim_mem[trim_slot(act_supply, 1'b1, int'(act_gen))] = cur_code;
    run_busy = 1'b0;
    r.done   = 1'b1;
    r.passed = hit;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_tally++;
    end
  endtask

  // result beats are popped before the same edge's input beat is pushed
  always @(posedge clk) begin
    trim_res_t want;
    trim_res_t got;
    if (!rst_n) begin
      trim_reset();
      want_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.code_out, out_ch.done_res, out_ch.passed, out_ch.skipped};
        if (want_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual code %0d done %0d",
                   $time, got.code, got.done);
          err_tally++;
        end else begin
          want = want_q.pop_front();
          check_field("code_out", want.code, got.code);
          check_field("done_res", want.done, got.done);
          check_field("passed", want.passed, got.passed);
          check_field("skipped", want.skipped, got.skipped);
        end
      end
      if (in_ch.valid && in_ch.ready)
        want_q.push_back(predict_trim(in_ch.operation, in_ch.supply_select, in_ch.speed_gen,
                                      in_ch.comparator_high, in_ch.tx_idle,
                                      in_ch.rx_squelch));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CONTINUOUS: live_cfg.continuous   = cfg_data[0];
          CFG_OVERRIDE:   live_cfg.override_en  = cfg_data[0];
          CFG_SERDES:     live_cfg.serdes       = cfg_data[0];
          CFG_DEF_CODE:   live_cfg.default_code = cfg_data[CODE_W-1:0];
          CFG_RUN_LIMIT:  live_cfg.run_limit    = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= want_q.size();
  end

endmodule

// File: tb/supply_trim_calibrator_tb.sv
// Testbench top of the supply trim calibrator: clock, reset, stimulus and verdict.
module supply_trim_calibrator_tb;
  import stc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GENS        = 4;
  localparam int SUPPLIES    = 6;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_BEATS = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    err_count;
  int                    pending;
  int                    beats_sent = 0;
  int                    quiet_cycles = 0;
  int                    hold_left = 0;
  bit                    calm = 1'b0;
  bit                    hold_req = 1'b0;
  bit                    hold_seen = 1'b0;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  supply_trim_calibrator #(.NUM_GENS(GENS), .NUM_SUPPLIES(SUPPLIES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  supply_trim_calibrator_chk #(.NUM_GENS(GENS), .NUM_SUPPLIES(SUPPLIES)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .err_count (err_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random back-pressure unless calm, one long hold-off when asked
  always @(posedge clk) begin
    hold_seen <= hold_req;
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // offer one beat, with random gaps ahead of it, and wait until it is taken
  task automatic send_beat(logic op, logic [SUPPLY_W-1:0] sup, logic [GEN_W-1:0] gen,
                           logic comp, logic idle, logic sq);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.supply_select   <= sup;
    in_ch.speed_gen       <= gen;
    in_ch.comparator_high <= comp;
    in_ch.tx_idle         <= idle;
    in_ch.rx_squelch      <= sq;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic start_run(logic [SUPPLY_W-1:0] sup, logic [GEN_W-1:0] gen,
                           logic idle, logic sq);
    send_beat(OP_START, sup, gen, 1'($urandom_range(0, 1)), idle, sq);
  endtask

  task automatic sample_comp(logic comp);
    send_beat(OP_SAMPLE, SUPPLY_W'($urandom_range(0, 7)), GEN_W'($urandom_range(0, 3)), comp,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONTINUOUS;
    cfg_data  <= CFG_DATA_W'(c.continuous);
    @(posedge clk);
    cfg_index <= CFG_OVERRIDE;
    cfg_data  <= CFG_DATA_W'(c.override_en);
    @(posedge clk);
    cfg_index <= CFG_SERDES;
    cfg_data  <= CFG_DATA_W'(c.serdes);
    @(posedge clk);
    cfg_index <= CFG_DEF_CODE;
    cfg_data  <= CFG_DATA_W'(c.default_code);
    @(posedge clk);
    cfg_index <= CFG_RUN_LIMIT;
    cfg_data  <= CFG_DATA_W'(c.run_limit);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    cfg_t phase_cfg;
    int   phase_end;
    int   n;
    int   kind;
    logic bitv;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_START;
    in_ch.supply_select   = '0;
    in_ch.speed_gen       = '0;
    in_ch.comparator_high = 1'b0;
    in_ch.tx_idle         = 1'b0;
    in_ch.rx_squelch      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: one-time search from code 8, limit 32
    sample_comp(1'b1);                 // sample with no run open
    start_run(3'd0, 2'd0, 1'b0, 1'b0);
    sample_comp(1'b1);
    sample_comp(1'b0);
    sample_comp(1'b1);                 // 0101 dither, pass
    sample_comp(1'b0);                 // idle again, code held
    start_run(3'd7, 2'd0, 1'b0, 1'b0); // supply out of range
    start_run(3'd6, 2'd3, 1'b1, 1'b1);
    start_run(3'd5, 2'd3, 1'b1, 1'b1); // indicators ignored in one-time mode
    sample_comp(1'b0);
    sample_comp(1'b0);
    sample_comp(1'b0);
    start_run(3'd2, 2'd1, 1'b0, 1'b0); // restart while busy
    sample_comp(1'b1);
    sample_comp(1'b1);
    sample_comp(1'b1);
    sample_comp(1'b0);
    sample_comp(1'b1);
    sample_comp(1'b0);                 // 1010 dither, pass
    drain_results();

    // directed, continuous tracking: refusals, then one step from stored codes
    phase_cfg = '{1'b1, 1'b0, 1'b0, DEF_CODE_RST, RUN_LIMIT_RST};
    load_config(phase_cfg);
    start_run(3'd0, 2'd0, 1'b1, 1'b0); // idle transmitter
    start_run(3'd3, 2'd2, 1'b0, 1'b1); // squelched receiver
    start_run(3'd0, 2'd0, 1'b0, 1'b1);
    sample_comp(1'b0);
    start_run(3'd3, 2'd0, 1'b1, 1'b0);
    sample_comp(1'b1);                 // saturates at zero
    drain_results();

    // random phases over a spread of settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_cfg.continuous   = 1'($urandom_range(0, 1));
      phase_cfg.override_en  = ($urandom_range(0, 4) == 0);
      phase_cfg.serdes       = 1'($urandom_range(0, 1));
      phase_cfg.default_code = CODE_W'($urandom_range(0, 15));
      phase_cfg.run_limit    = RUN_W'($urandom_range(0, 15));
      case (p)
        0: phase_cfg = '{1'b0, 1'b0, 1'b0, CODE_MIN, 6'd0};
        1: phase_cfg = '{1'b0, 1'b0, 1'b0, CODE_MAX, 6'd63};
        2: begin
          phase_cfg.continuous  = 1'b0;
          phase_cfg.override_en = 1'b0;
          phase_cfg.serdes      = 1'b1;
        end
        3: begin
          phase_cfg.continuous  = 1'b1;
          phase_cfg.override_en = 1'b0;
          phase_cfg.serdes      = 1'b0;
        end
        4: begin
          phase_cfg.continuous  = 1'b0;
          phase_cfg.override_en = 1'b0;
        end
        5: begin
          phase_cfg.continuous  = 1'b1;
          phase_cfg.override_en = 1'b0;
          phase_cfg.serdes      = 1'b1;
        end
        6: begin
          phase_cfg.continuous  = 1'b0;
          phase_cfg.override_en = 1'b1;
        end
        7: begin
          phase_cfg.continuous  = 1'b1;
          phase_cfg.override_en = 1'b1;
        end
        default: ;
      endcase
      load_config(phase_cfg);
      hold_req <= (p == 3);
      calm     <= (p == 4);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 99) < 10) begin
          // noise beat, any field value
          send_beat(1'($urandom_range(0, 1)), SUPPLY_W'($urandom_range(0, 7)),
                    GEN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          // well-formed run: start then a burst of comparator samples
          start_run(SUPPLY_W'($urandom_range(0, SUPPLIES - 1)), GEN_W'($urandom_range(0, 3)),
                    ($urandom_range(0, 2) == 0), ($urandom_range(0, 2) == 0));
          if ($urandom_range(0, 3) == 0) n = int'(phase_cfg.run_limit) + 2;
          else n = $urandom_range(1, 8);
          kind = $urandom_range(0, 2);
          bitv = 1'($urandom_range(0, 1));
          for (int k = 0; k < n; k++) begin
            case (kind)
              0: bitv = 1'($urandom_range(0, 1));
              2: if (k >= 2) bitv = ~bitv;
              default: ;
            endcase
            sample_comp(bitv);
          end
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
